>>> design/ntc_pkg.sv
// Shared constants, calibration table and types for the NTC table interpolator.
package ntc_pkg;

  // Field widths
  localparam int ADC_BITS  = 12;
  localparam int OUT_BITS  = 17;
  localparam int IN_TDATA  = 16;
  localparam int OUT_TDATA = 24;

  // Calibration table: readings strictly descend, temperatures in whole degrees
  localparam int ROM_SIZE     = 12;
  localparam int IDX_BITS     = 4;
  localparam int SEARCH_STEPS = 4;
  localparam int CEL_BITS     = 8;

  localparam logic [ADC_BITS-1:0] ROM_READING [ROM_SIZE] = '{
    12'd3914, 12'd3861, 12'd3733, 12'd3637, 12'd3310, 12'd2439,
    12'd2035, 12'd1647, 12'd1301, 12'd1011, 12'd777,  12'd454
  };

  localparam logic signed [CEL_BITS-1:0] ROM_CELSIUS [ROM_SIZE] = '{
    -8'sd20, -8'sd10, 8'sd0,  8'sd10, 8'sd25,  8'sd50,
    8'sd60,  8'sd70,  8'sd80, 8'sd90, 8'sd100, 8'sd120
  };

  // Arithmetic widths
  localparam int DT_BITS   = CEL_BITS + 1;       // temperature difference
  localparam int DX_BITS   = ADC_BITS + 1;       // reading offset from upper entry
  localparam int MUL_BITS  = DT_BITS + DX_BITS;  // signed product
  localparam int PROD_BITS = 20;                 // product magnitude
  localparam int DEN_BITS  = ADC_BITS;           // reading difference of a segment
  localparam int DEN2_BITS = DEN_BITS + 1;       // twice the reading difference
  localparam int DIVD_BITS = PROD_BITS + 10;     // 512 * magnitude + difference
  localparam int QUOT_BITS = 19;                 // rounded quotient magnitude
  localparam int RES_BITS  = 21;                 // unsaturated result

  localparam logic signed [RES_BITS-1:0] RES_MIN = -21'sd14336;
  localparam logic signed [RES_BITS-1:0] RES_MAX = 21'sd38400;

  // Queue between the search front and the divider back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;

  // One queued transaction: everything the back end needs
  typedef struct packed {
    logic                       neg;
    logic [PROD_BITS-1:0]       prod;
    logic [DEN_BITS-1:0]        den;
    logic signed [CEL_BITS-1:0] thi;
  } ntc_work_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } ntc_qstat_t;

endpackage

>>> design/ntc_table_interpolator.sv
// Top level of the NTC thermistor table interpolator.
//
//  channel  dir  handshake            payload
//  s_axis   in   s_tvalid / s_tready  s_tdata[11:0] adc_sample
//  m_axis   out  m_tvalid / m_tready  m_tdata[16:0] temperature_q8
//
//  One transaction per cycle while m_tready is not held low; from acceptance to
//  m_tvalid a sample passes one search stage, one queue slot, 19 divider stages
//  (one quotient bit each) and the output register.
//  Reset (rst, synchronous) empties the queue and clears all valid bits.
//  A stalled output holds the divider pipeline; the front keeps filling the
//  four-entry queue and drops s_tready only when it is full.
module ntc_table_interpolator
  import ntc_pkg::*;
#(
  parameter int TABLE_ENTRIES = 12,
  parameter int SAMPLE_BITS   = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_TDATA-1:0]  s_tdata,   // [11:0] adc_sample, [15:12] zero
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_TDATA-1:0] m_tdata    // [16:0] temperature_q8, [23:17] zero
);

  ntc_qstat_t          qstat;
  ntc_work_t           push_data;
  ntc_work_t           head;
  logic                push;
  logic                pop;
  logic                head_valid;
  logic [OUT_BITS-1:0] temp;

  // Search and product
  ntc_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_sample(s_tdata[ADC_BITS-1:0]),
    .in_ready (s_tready),
    .qstat    (qstat),
    .push     (push),
    .push_data(push_data)
  );

  // Decoupling queue
  ntc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .head_valid(head_valid),
    .qstat     (qstat)
  );

  // Division, offset and saturation
  ntc_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .temp_valid(m_tvalid),
    .temp      (temp),
    .temp_ready(m_tready)
  );

  assign m_tdata = {{(OUT_TDATA - OUT_BITS){1'b0}}, temp};

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("push into full queue");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

  // Input acceptance follows queue room
  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    s_tready == !qstat.full)
    else $error("s_tready disagrees with queue status");

  // Delivered temperatures stay inside the saturation range
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[OUT_BITS-1:0]) >= $signed(RES_MIN[OUT_BITS-1:0]) &&
                  $signed(m_tdata[OUT_BITS-1:0]) <= $signed(RES_MAX[OUT_BITS-1:0])))
    else $error("temperature outside saturation range");

endmodule

>>> design/ntc_front.sv
// Front end: accept a sample, search the table, fetch the segment and form the product.
module ntc_front
  import ntc_pkg::*;
#(
  parameter int TABLE_ENTRIES = 12,
  parameter int SAMPLE_BITS   = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [ADC_BITS-1:0] in_sample,
  output logic                in_ready,
  input  ntc_qstat_t          qstat,
  output logic                push,
  output ntc_work_t           push_data
);

  localparam int USED = (TABLE_ENTRIES > ROM_SIZE) ? ROM_SIZE :
                        ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES);
  localparam int KEEP = (SAMPLE_BITS < ADC_BITS) ? SAMPLE_BITS : ADC_BITS;
  localparam logic [ADC_BITS-1:0] SAMPLE_MASK = {ADC_BITS{1'b1}} >> (ADC_BITS - KEEP);

  logic                        adv;
  logic [ADC_BITS-1:0]         x;
  logic [IDX_BITS-1:0]         lo, hi;
  logic signed [DT_BITS-1:0]   dt_next;
  logic signed [DX_BITS-1:0]   dx_next;
  logic [DEN_BITS-1:0]         den_next;

  logic                        s1_valid;
  logic signed [DT_BITS-1:0]   s1_dt;
  logic signed [DX_BITS-1:0]   s1_dx;
  logic [DEN_BITS-1:0]         s1_den;
  logic signed [CEL_BITS-1:0]  s1_thi;
  logic signed [MUL_BITS-1:0]  prod;
  logic signed [MUL_BITS-1:0]  prod_abs;

  // Advance whenever the queue has room
  assign adv      = !qstat.full;
  assign in_ready = adv;
  assign x        = in_sample & SAMPLE_MASK;

  // Binary search for the bracketing pair of neighbouring entries
  always_comb begin
    logic [IDX_BITS-1:0] m;
    m  = '0;
    lo = '0;
    hi = IDX_BITS'(USED - 1);
    for (int s = 0; s < SEARCH_STEPS; s++) begin
      if (IDX_BITS'(hi - lo) > IDX_BITS'(1)) begin
        m = IDX_BITS'(((IDX_BITS + 1)'(lo) + (IDX_BITS + 1)'(hi)) >> 1);
        if (ROM_READING[m] > x) begin
          lo = m;
        end else begin
          hi = m;
        end
      end
    end
  end

  // Segment differences for the chosen pair
  always_comb begin
    dt_next  = DT_BITS'(ROM_CELSIUS[lo]) - DT_BITS'(ROM_CELSIUS[hi]);
    dx_next  = $signed({1'b0, x}) - $signed({1'b0, ROM_READING[hi]});
    den_next = ROM_READING[lo] - ROM_READING[hi];
  end

  // Hold the search result
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dt  <= dt_next;
      s1_dx  <= dx_next;
      s1_den <= den_next;
      s1_thi <= ROM_CELSIUS[hi];
    end
  end

  // Form the signed product and split it into sign and magnitude for the queue
  assign prod     = MUL_BITS'(s1_dt) * MUL_BITS'(s1_dx);
  assign prod_abs = prod[MUL_BITS-1] ? -prod : prod;

  assign push           = s1_valid && adv;
  assign push_data.neg  = prod[MUL_BITS-1];
  assign push_data.prod = prod_abs[PROD_BITS-1:0];
  assign push_data.den  = s1_den;
  assign push_data.thi  = s1_thi;

endmodule

>>> design/ntc_queue.sv
// Short queue of segment transactions between the front and the divider.
module ntc_queue
  import ntc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  ntc_work_t  push_data,
  input  logic       pop,
  output ntc_work_t  head,
  output logic       head_valid,
  output ntc_qstat_t qstat
);

  ntc_work_t            mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wp, rp;
  logic [QPTR_BITS:0]   cnt;

  // Track fill level and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_data;
    end
  end

  assign head        = mem[rp];
  assign head_valid  = (cnt != '0);
  assign qstat.empty = (cnt == '0);
  assign qstat.full  = (cnt == (QPTR_BITS + 1)'(QUEUE_DEPTH));

endmodule

>>> design/ntc_divider.sv
// Back end: pipelined rounding divider, offset by the upper entry, saturation.
module ntc_divider
  import ntc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  ntc_work_t           head,
  output logic                pop,
  output logic                temp_valid,
  output logic [OUT_BITS-1:0] temp,
  input  logic                temp_ready
);

  localparam int W = DEN2_BITS + QUOT_BITS;

  logic                        adv;
  logic [DIVD_BITS-1:0]        dividend;
  logic [DEN2_BITS-1:0]        dvs0;

  logic [QUOT_BITS-1:0]        vld;
  logic [DIVD_BITS-1:0]        rem      [QUOT_BITS];
  logic [DIVD_BITS-1:0]        rem_next [QUOT_BITS];
  logic [QUOT_BITS-1:0]        quo      [QUOT_BITS];
  logic [QUOT_BITS-1:0]        quo_next [QUOT_BITS];
  logic [DEN2_BITS-1:0]        dvs      [QUOT_BITS];
  logic                        neg      [QUOT_BITS];
  logic signed [CEL_BITS-1:0]  thi      [QUOT_BITS];

  logic signed [RES_BITS-1:0]  qs;
  logic signed [RES_BITS-1:0]  res;
  logic [OUT_BITS-1:0]         temp_next;

  // One restoring step: returns {quotient bit, new remainder}
  function automatic logic [DIVD_BITS:0] try_bit(input logic [DIVD_BITS-1:0] r,
                                                 input logic [DEN2_BITS-1:0] d,
                                                 input int k);
    logic [W-1:0] sh;
    logic         tk;
    sh = W'(d) << k;
    tk = (W'(r) >= sh);
    return {tk, tk ? (r - sh[DIVD_BITS-1:0]) : r};
  endfunction

  // Advance the whole back end when the output slot is free or being taken
  assign adv = !temp_valid || temp_ready;
  assign pop = head_valid && adv;

  // Rounded division: (512 * |p| + den) / (2 * den)
  assign dividend = DIVD_BITS'({head.prod, 9'd0}) + DIVD_BITS'(head.den);
  assign dvs0     = {head.den, 1'b0};

  // Resolve one quotient bit per stage, most significant first
  always_comb begin
    logic [DIVD_BITS:0] step;
    step        = try_bit(dividend, dvs0, QUOT_BITS - 1);
    rem_next[0] = step[DIVD_BITS-1:0];
    quo_next[0] = '0;
    quo_next[0][QUOT_BITS-1] = step[DIVD_BITS];
    for (int j = 1; j < QUOT_BITS; j++) begin
      step        = try_bit(rem[j-1], dvs[j-1], QUOT_BITS - 1 - j);
      rem_next[j] = step[DIVD_BITS-1:0];
      quo_next[j] = quo[j-1];
      quo_next[j][QUOT_BITS-1-j] = step[DIVD_BITS];
    end
  end

  // Shift valid bits and the output flag
  always_ff @(posedge clk) begin
    if (rst) begin
      vld        <= '0;
      temp_valid <= 1'b0;
    end else if (adv) begin
      vld        <= {vld[QUOT_BITS-2:0], head_valid};
      temp_valid <= vld[QUOT_BITS-1];
    end
  end

  // Move payload through the divider stages
  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0] <= rem_next[0];
      quo[0] <= quo_next[0];
      dvs[0] <= dvs0;
      neg[0] <= head.neg;
      thi[0] <= head.thi;
      for (int j = 1; j < QUOT_BITS; j++) begin
        rem[j] <= rem_next[j];
        quo[j] <= quo_next[j];
        dvs[j] <= dvs[j-1];
        neg[j] <= neg[j-1];
        thi[j] <= thi[j-1];
      end
      temp <= temp_next;
    end
  end

  // Apply sign, add the upper entry, saturate
  always_comb begin
    qs = $signed(RES_BITS'(quo[QUOT_BITS-1]));
    if (neg[QUOT_BITS-1]) begin
      qs = -qs;
    end
    // flat segment: no slope, upper entry only
    if (dvs[QUOT_BITS-1] == '0) begin
      qs = '0;
    end
    res = qs + (RES_BITS'(thi[QUOT_BITS-1]) <<< 8);
    if (res < RES_MIN) begin
      temp_next = RES_MIN[OUT_BITS-1:0];
    end else if (res > RES_MAX) begin
      temp_next = RES_MAX[OUT_BITS-1:0];
    end else begin
      temp_next = res[OUT_BITS-1:0];
    end
  end

endmodule

>>> sim/ntc_table_interpolator_tb.sv
// Self-checking testbench for the NTC thermistor table interpolator.
module ntc_table_interpolator_tb;
  import ntc_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int CAL_ENTRIES  = 12;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int REPORT_MAX   = 10;
  localparam longint TEMP_MIN = -14336;
  localparam longint TEMP_MAX = 38400;

  // Calibration points: readings descend, temperatures in whole degrees
  localparam int CAL_READING [CAL_ENTRIES] = '{
    3914, 3861, 3733, 3637, 3310, 2439, 2035, 1647, 1301, 1011, 777, 454
  };
  localparam int CAL_CELSIUS [CAL_ENTRIES] = '{
    -20, -10, 0, 10, 25, 50, 60, 70, 80, 90, 100, 120
  };

  typedef struct {
    logic [ADC_BITS-1:0] sample;
    logic [OUT_BITS-1:0] temp_q8;
  } temp_expect_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_TDATA-1:0]  s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_TDATA-1:0] m_tdata;

  temp_expect_t pending_temps [$];
  temp_expect_t oldest_temp;
  int mismatch_count = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int rx_hold_cycles = 0;

  ntc_table_interpolator uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Search the bracketing pair, interpolate with round-half-away, saturate
  function automatic logic [OUT_BITS-1:0] ntc_temp_q8(input logic [ADC_BITS-1:0] smp);
    int lo;
    int hi;
    int mid;
    longint x;
    longint v_lo;
    longint v_hi;
    longint t_lo;
    longint t_hi;
    longint span;
    longint num;
    longint quot;
    longint temp;
    x = longint'(smp);
    lo = 0;
    hi = CAL_ENTRIES - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (longint'(CAL_READING[mid]) > x) lo = mid;
      else hi = mid;
    end
    v_lo = CAL_READING[lo];
    v_hi = CAL_READING[hi];
    t_lo = CAL_CELSIUS[lo];
    t_hi = CAL_CELSIUS[hi];
    span = v_lo - v_hi;
    if (span > 0) begin
      num = 256 * (t_lo - t_hi) * (x - v_hi);
      if (num >= 0) quot = (2 * num + span) / (2 * span);
      else quot = -((-2 * num + span) / (2 * span));
      temp = quot + 256 * t_hi;
    end else begin
      // flat segment: take the upper-index temperature
      temp = 256 * t_hi;
    end
    if (temp < TEMP_MIN) temp = TEMP_MIN;
    if (temp > TEMP_MAX) temp = TEMP_MAX;
    return temp[OUT_BITS-1:0];
  endfunction

  // Record accepted samples, compare each output transaction with the oldest one
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_temps.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("unexpected output transaction: tdata %h", m_tdata);
        end else begin
          oldest_temp = pending_temps.pop_front();
          if (m_tdata !== {{(OUT_TDATA-OUT_BITS){1'b0}}, oldest_temp.temp_q8}) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
              $display("mismatch: adc %0d expected %0d (tdata %h) got %0d (tdata %h)",
                       oldest_temp.sample, $signed(oldest_temp.temp_q8),
                       {{(OUT_TDATA-OUT_BITS){1'b0}}, oldest_temp.temp_q8},
                       $signed(m_tdata[OUT_BITS-1:0]), m_tdata);
          end
        end
      end
      if (s_tvalid && s_tready)
        pending_temps.push_back('{sample: s_tdata[ADC_BITS-1:0],
                                  temp_q8: ntc_temp_q8(s_tdata[ADC_BITS-1:0])});
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Drive m_tready: runs and short stalls, plus a long hold-off on request
  initial begin : rx_driver
    int run_len;
    int stall_len;
    int k;
    @(negedge rst);
    forever begin
      if (rx_hold_cycles > 0) begin
        m_tready <= 1'b0;
        for (k = 0; k < rx_hold_cycles; k++) @(posedge clk);
        rx_hold_cycles = 0;
      end
      run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 12);
      m_tready <= 1'b1;
      // cut the run short once a hold-off is requested
      for (k = 0; k < run_len && (k == 0 || rx_hold_cycles == 0); k++) @(posedge clk);
      stall_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (stall_len > 0) begin
        m_tready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  // Offer one sample and hold it until accepted; may idle between bursts
  task automatic send_sample(input logic [ADC_BITS-1:0] smp);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(10, 30);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA-ADC_BITS){1'b0}}, smp};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
  endtask

  // Stop offering and wait for every expected transaction to come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_temps.size() != 0) @(posedge clk);
  endtask

  // Pick a reading: half uniform, some near breakpoints, some beyond the table
  function automatic logic [ADC_BITS-1:0] random_reading();
    int pick;
    int idx;
    pick = $urandom_range(0, 19);
    if (pick < 10) return ADC_BITS'($urandom_range(0, 4095));
    if (pick < 15) begin
      idx = $urandom_range(0, CAL_ENTRIES - 1);
      return ADC_BITS'(CAL_READING[idx] + $urandom_range(0, 16) - 8);
    end
    if (pick < 17) return ADC_BITS'($urandom_range(3914, 4095));
    return ADC_BITS'($urandom_range(0, 454));
  endfunction

  // Range ends, every breakpoint, neighbors of the end breakpoints, extrapolation at both ends
  task automatic test_table_corners();
    int corner_pts [22] = '{
      0, 1, 4094, 4095, 453, 455, 3913, 3915, 2048, 2047, 3914,
      3861, 3733, 3637, 3310, 2439, 2035, 1647, 1301, 1011, 777, 454
    };
    foreach (corner_pts[i]) send_sample(ADC_BITS'(corner_pts[i]));
  endtask

  task automatic test_random_stream();
    repeat (1350) send_sample(random_reading());
  endtask

  // Hold the output off long enough that the input stalls
  task automatic test_output_backpressure();
    rx_hold_cycles = HOLD_CYCLES;
    repeat (100) send_sample(random_reading());
  endtask

  // Short bursts, each followed by a full drain
  task automatic test_drain_pauses();
    repeat (3) begin
      repeat (25) send_sample(random_reading());
      wait_drained();
    end
  endtask

  initial begin : main
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_table_corners();
    test_random_stream();
    test_output_backpressure();
    test_drain_pauses();
    s_tvalid <= 1'b0;
    while (pending_temps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_temps.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/ntc_pkg.sv
design/ntc_front.sv
design/ntc_queue.sv
design/ntc_divider.sv
design/ntc_table_interpolator.sv
sim/ntc_table_interpolator_tb.sv
